// ===== src/nmea_rmc_time_date_extractor_macros.svh =====
// ----------------------------------------------------------------------------
// NMEA RMC extractor assertion macros
// Concurrent check wrappers, compiled out when NO_ASSERTIONS is set.
// ----------------------------------------------------------------------------
`ifndef NMEA_RMC_TIME_DATE_EXTRACTOR_MACROS_SVH
`define NMEA_RMC_TIME_DATE_EXTRACTOR_MACROS_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define NRTE_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("nrte: implication check failed");

// next-cycle implication
`define NRTE_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("nrte: next-cycle check failed");

`else

`define NRTE_ASSERT_IMP(label, ante, cons)

`define NRTE_ASSERT_NXT(label, ante, cons)

`endif

`endif

// ===== src/nrte_pkg.sv =====
// ----------------------------------------------------------------------------
// NMEA RMC extractor package
// Shared types and constants for the parser front, queue and decode back.
// ----------------------------------------------------------------------------
`default_nettype none

package nrte_pkg;

	localparam int unsigned FieldLen     = 6;
	localparam int unsigned NumPairs     = FieldLen / 2;
	localparam int unsigned TagLen       = 6;
	localparam int unsigned DotSkip      = 4;
	localparam int unsigned CommasToDate = 1 + 7;
	localparam int unsigned AsciiZero    = 48;
	localparam int unsigned YearBase     = 2000;
	localparam int unsigned QueueDepth   = 2;
	localparam int unsigned QPtrW        = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
	localparam int unsigned QCountW      = $clog2(QueueDepth + 1);

	typedef logic [7:0] char_t;
	typedef logic [2:0] pos_t;

	typedef enum logic {
		REQ_BYTE    = 1'b0,
		REQ_RESTART = 1'b1
	} req_t;

	localparam char_t ChDollar = 8'h24;
	localparam char_t ChG      = 8'h47;
	localparam char_t ChR      = 8'h52;
	localparam char_t ChM      = 8'h4D;
	localparam char_t ChC      = 8'h43;
	localparam char_t ChComma  = 8'h2C;

	localparam pos_t TagIdxDollar = 3'd0;
	localparam pos_t TagIdxG      = 3'd1;
	localparam pos_t TagIdxR      = 3'd3;
	localparam pos_t TagIdxM      = 3'd4;
	localparam pos_t TagIdxC      = 3'd5;

	typedef struct packed {
		logic                     done;
		logic                     time_flag;
		logic                     date_flag;
		char_t [FieldLen-1:0]     time_chars;
		char_t [FieldLen-1:0]     date_chars;
	} nrte_entry_t;

endpackage

`default_nettype wire

// ===== src/nrte_front.sv =====
// ----------------------------------------------------------------------------
// NMEA RMC extractor front
// Accepts bytes and restarts, runs the sentence parser and queues a snapshot.
// ----------------------------------------------------------------------------
`default_nettype none

module nrte_front
	import nrte_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic        req_type,
	input  wire logic [7:0]  byte_value,
	output logic             push,
	output nrte_entry_t      push_entry,
	input  wire logic        full
);

	logic [2:0]           skip_q, skip_n;
	logic [3:0]           comma_q, comma_n;
	pos_t                 tag_pos_q, tag_pos_n;
	logic                 tag_ok_q, tag_ok_n;
	logic                 tag_matched_q, tag_matched_n;
	pos_t                 time_pos_q, time_pos_n;
	pos_t                 date_pos_q, date_pos_n;
	char_t [FieldLen-1:0] time_chars_q, time_chars_n;
	char_t [FieldLen-1:0] date_chars_q, date_chars_n;
	logic                 time_we, date_we, done;
	pos_t                 tag_idx;
	logic                 char_ok;
	logic                 accept;

	assign in_stall = full;
	assign accept   = in_valid && !full;
	assign push     = accept;

	always_comb begin
		skip_n        = skip_q;
		comma_n       = comma_q;
		tag_pos_n     = tag_pos_q;
		tag_ok_n      = tag_ok_q;
		tag_matched_n = tag_matched_q;
		time_pos_n    = time_pos_q;
		date_pos_n    = date_pos_q;
		time_we       = 1'b0;
		date_we       = 1'b0;
		done          = 1'b0;
		tag_idx       = tag_pos_q;
		char_ok       = 1'b1;
		if (req_t'(req_type) == REQ_RESTART) begin
			skip_n        = '0;
			comma_n       = '0;
			tag_pos_n     = '0;
			tag_ok_n      = 1'b0;
			tag_matched_n = 1'b0;
			time_pos_n    = '0;
			date_pos_n    = '0;
		end else if (skip_q != '0) begin
			skip_n = skip_q - 3'd1;
		end else if (comma_q != '0) begin
			if (byte_value == ChComma) begin
				comma_n = comma_q - 4'd1;
			end
		end else if (!tag_matched_q) begin
			if (byte_value == ChDollar) begin
				tag_idx = '0;
			end
			case (tag_idx)
				TagIdxDollar: char_ok = (byte_value == ChDollar);
				TagIdxG:      char_ok = (byte_value == ChG);
				TagIdxR:      char_ok = (byte_value == ChR);
				TagIdxM:      char_ok = (byte_value == ChM);
				TagIdxC:      char_ok = (byte_value == ChC);
				default:      char_ok = 1'b1;
			endcase
			tag_ok_n = char_ok && ((tag_idx == TagIdxDollar) || tag_ok_q);
			if (tag_idx == pos_t'(TagLen - 1)) begin
				if (tag_ok_n) begin
					tag_matched_n = 1'b1;
					skip_n        = 3'd1;
					tag_pos_n     = pos_t'(TagLen);
				end else begin
					tag_pos_n = '0;
				end
			end else begin
				tag_pos_n = tag_idx + 3'd1;
			end
		end else if (time_pos_q != pos_t'(FieldLen)) begin
			time_we    = 1'b1;
			time_pos_n = time_pos_q + 3'd1;
			if (time_pos_q == pos_t'(FieldLen - 1)) begin
				skip_n  = 3'(DotSkip);
				comma_n = 4'(CommasToDate);
			end
		end else if (date_pos_q != pos_t'(FieldLen)) begin
			date_we    = 1'b1;
			date_pos_n = date_pos_q + 3'd1;
			done       = (date_pos_q == pos_t'(FieldLen - 1));
		end else begin
			done = 1'b1;
		end
	end

	always_comb begin
		time_chars_n = time_chars_q;
		date_chars_n = date_chars_q;
		if (time_we) begin
			time_chars_n[time_pos_q] = byte_value;
		end
		if (date_we) begin
			date_chars_n[date_pos_q] = byte_value;
		end
	end

	always_comb begin
		push_entry.done       = done;
		push_entry.time_flag  = (time_pos_n == pos_t'(FieldLen));
		push_entry.date_flag  = (date_pos_n == pos_t'(FieldLen));
		push_entry.time_chars = time_chars_n;
		push_entry.date_chars = date_chars_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			skip_q        <= '0;
			comma_q       <= '0;
			tag_pos_q     <= '0;
			tag_ok_q      <= 1'b0;
			tag_matched_q <= 1'b0;
			time_pos_q    <= '0;
			date_pos_q    <= '0;
		end else if (accept) begin
			skip_q        <= skip_n;
			comma_q       <= comma_n;
			tag_pos_q     <= tag_pos_n;
			tag_ok_q      <= tag_ok_n;
			tag_matched_q <= tag_matched_n;
			time_pos_q    <= time_pos_n;
			date_pos_q    <= date_pos_n;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			time_chars_q <= time_chars_n;
			date_chars_q <= date_chars_n;
		end
	end

endmodule

`default_nettype wire

// ===== src/nrte_queue.sv =====
// ----------------------------------------------------------------------------
// NMEA RMC extractor queue
// Short register queue between parser front and decode back.
// ----------------------------------------------------------------------------
`default_nettype none

module nrte_queue
	import nrte_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        push,
	input  wire nrte_entry_t push_entry,
	output logic             full,
	input  wire logic        pop,
	output nrte_entry_t      pop_entry,
	output logic             empty
);

	nrte_entry_t           slots_q [QueueDepth];
	logic [QPtrW-1:0]      wr_ptr_q;
	logic [QPtrW-1:0]      rd_ptr_q;
	logic [QCountW-1:0]    count_q;

	assign full      = (count_q == QCountW'(QueueDepth));
	assign empty     = (count_q == '0);
	assign pop_entry = slots_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= push_entry;
		end
	end

endmodule

`default_nettype wire

// ===== src/nrte_back.sv =====
// ----------------------------------------------------------------------------
// NMEA RMC extractor back
// Decodes queued digit pairs into time and date values and registers results.
// ----------------------------------------------------------------------------
`default_nettype none

module nrte_back
	import nrte_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	output logic             pop,
	input  wire nrte_entry_t pop_entry,
	input  wire logic        empty,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic             done_res,
	output logic             hms_valid,
	output logic             dmy_valid,
	output logic [6:0]       hour,
	output logic [6:0]       minute,
	output logic [6:0]       second,
	output logic [6:0]       day,
	output logic [6:0]       month,
	output logic [11:0]      year,
	output logic             bad_digit
);

	function automatic logic is_digit(input char_t c);
		return (c >= 8'(AsciiZero)) && (c <= 8'(AsciiZero + 9));
	endfunction

	function automatic logic [6:0] pair_value(input char_t hi, input char_t lo);
		logic [6:0] dh;
		logic [6:0] dl;
		dh = {3'b0, 4'(hi - 8'(AsciiZero))};
		dl = {3'b0, 4'(lo - 8'(AsciiZero))};
		return (dh << 3) + (dh << 1) + dl;
	endfunction

	logic [6:0] tval [NumPairs];
	logic [6:0] dval [NumPairs];
	logic       tbad [NumPairs];
	logic       dbad [NumPairs];
	logic       any_bad;

	logic       out_valid_q;
	logic       done_q, hms_valid_q, dmy_valid_q, bad_q;
	logic [6:0] hour_q, minute_q, second_q, day_q, month_q;
	logic [11:0] year_q;

	assign pop = !empty && (!out_valid_q || !out_stall);

	always_comb begin
		any_bad = 1'b0;
		for (int i = 0; i < NumPairs; i++) begin
			tbad[i] = !is_digit(pop_entry.time_chars[2*i]) ||
				!is_digit(pop_entry.time_chars[2*i+1]);
			dbad[i] = !is_digit(pop_entry.date_chars[2*i]) ||
				!is_digit(pop_entry.date_chars[2*i+1]);
			tval[i] = (pop_entry.time_flag && !tbad[i]) ?
				pair_value(pop_entry.time_chars[2*i], pop_entry.time_chars[2*i+1]) : '0;
			dval[i] = (pop_entry.date_flag && !dbad[i]) ?
				pair_value(pop_entry.date_chars[2*i], pop_entry.date_chars[2*i+1]) : '0;
			any_bad = any_bad || (pop_entry.time_flag && tbad[i]) ||
				(pop_entry.date_flag && dbad[i]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			done_q      <= pop_entry.done;
			hms_valid_q <= pop_entry.time_flag;
			dmy_valid_q <= pop_entry.date_flag;
			hour_q      <= tval[0];
			minute_q    <= tval[1];
			second_q    <= tval[2];
			day_q       <= dval[0];
			month_q     <= dval[1];
			year_q      <= 12'(YearBase) + {5'b0, dval[2]};
			bad_q       <= any_bad;
		end
	end

	assign out_valid  = out_valid_q;
	assign done_res   = done_q;
	assign hms_valid  = hms_valid_q;
	assign dmy_valid  = dmy_valid_q;
	assign hour       = hour_q;
	assign minute     = minute_q;
	assign second     = second_q;
	assign day        = day_q;
	assign month      = month_q;
	assign year       = year_q;
	assign bad_digit  = bad_q;

endmodule

`default_nettype wire

// ===== src/nmea_rmc_time_date_extractor.sv =====
// Path: the parser writes each accepted item into the queue, and the decoder
// loads it from the queue into the output registers unless a shown result is stalled.
// Throughput: one item per cycle while the input is not stalled; the two-entry queue between parser and
// decoder stalls the input only when both entries are held.
// Reset: clears parser progress, queue pointers and the output valid; the
// captured character stores keep their contents and are never shown unset.
// ----------------------------------------------------------------------------
// NMEA RMC time and date extractor
// Parses GPS receiver bytes for an RMC sentence and reports time and date.
// ----------------------------------------------------------------------------
`default_nettype none

`include "nmea_rmc_time_date_extractor_macros.svh"

module nmea_rmc_time_date_extractor
	import nrte_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic        req_type,
	input  wire logic [7:0]  byte_value,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic             done_res,
	output logic             hms_valid,
	output logic             dmy_valid,
	output logic [6:0]       hour,
	output logic [6:0]       minute,
	output logic [6:0]       second,
	output logic [6:0]       day,
	output logic [6:0]       month,
	output logic [11:0]      year,
	output logic             bad_digit
);

	logic        q_push;
	logic        q_full;
	logic        q_pop;
	logic        q_empty;
	nrte_entry_t q_push_entry;
	nrte_entry_t q_pop_entry;

	nrte_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.req_type   (req_type),
		.byte_value (byte_value),
		.push       (q_push),
		.push_entry (q_push_entry),
		.full       (q_full)
	);

	nrte_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_entry (q_push_entry),
		.full       (q_full),
		.pop        (q_pop),
		.pop_entry  (q_pop_entry),
		.empty      (q_empty)
	);

	nrte_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.pop        (q_pop),
		.pop_entry  (q_pop_entry),
		.empty      (q_empty),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.done_res   (done_res),
		.hms_valid  (hms_valid),
		.dmy_valid  (dmy_valid),
		.hour       (hour),
		.minute     (minute),
		.second     (second),
		.day        (day),
		.month      (month),
		.year       (year),
		.bad_digit  (bad_digit)
	);

	`NRTE_ASSERT_IMP(a_done_has_date, out_valid && done_res, dmy_valid)
	`NRTE_ASSERT_IMP(a_date_has_time, out_valid && dmy_valid, hms_valid)
	`NRTE_ASSERT_IMP(a_no_time_zero, out_valid && !hms_valid, (hour | minute | second) == '0)
	`NRTE_ASSERT_NXT(a_full_holds, q_full && !q_pop, q_full)

endmodule

`default_nettype wire
